// ----- sv/mrdp_pkg.sv -----
// Package for the drive pilot: payload structs, codes, shared constants.
`default_nettype none
package mrdp_pkg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [31:0] plan_velocity;
        logic signed [31:0] plan_turn_rate;
        logic signed [31:0] dist_reference;
        logic signed [31:0] dist_measured;
        logic signed [31:0] heading_reference;
        logic signed [31:0] heading_measured;
        logic signed [31:0] heading_lead;
        logic               heading_enable;
        logic               within_tolerance;
        logic               idle_before;
        logic               idle_after;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] velocity_cmd;
        logic signed [31:0] turn_rate_cmd;
        logic [1:0]         stage_code;
    } out_item_t;

    localparam logic [2:0] REG_LIN_TAU  = 3'd0;
    localparam logic [2:0] REG_ANG_TAU  = 3'd1;
    localparam logic [2:0] REG_GAIN_P   = 3'd2;
    localparam logic [2:0] REG_GAIN_D   = 3'd3;
    localparam logic [2:0] REG_DIST_P   = 3'd4;
    localparam logic [2:0] REG_TRIM_LIM = 3'd5;

    localparam logic [1:0] STAGE_NOTHING = 2'd0;
    localparam logic [1:0] STAGE_TWIST   = 2'd1;
    localparam logic [1:0] STAGE_ZERO    = 2'd2;

    localparam int unsigned MS_PER_S = 1000;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/mrdp_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned 64 by 64.
`default_nettype none
module mrdp_div
    import mrdp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    div_state_t  state_reg, state_next;
    logic [63:0] quo_reg, rem_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (req.start) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == 6'd63) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb begin
        rsp.done = (state_reg == DIV_DONE);
        rsp.quo  = quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == DIV_RUN) cnt_reg <= cnt_reg + 6'd1;
            else cnt_reg <= '0;
        end
        if (state_reg == DIV_IDLE && req.start) begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end else if (state_reg == DIV_RUN) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/model_reference_drive_pilot.sv -----
// Top level of the drive pilot: sequencer, exp table, model state and output register.
// Each item runs through the sequencer in turn. Each of up to four divisions (two lag ratios,
// two rates) uses the shared 64-step divider; zero dt skips all of them, and zero tau
// skips the lag-ratio division of that lag.
// No new item is taken until the last one is out; s_ready is low while an item is in work.
// Reset (aresetn, synchronous, active low) restores register defaults and clears
// all model state; the exp table is a constant function, so no fill pass is needed.
`default_nettype none
module model_reference_drive_pilot
    import mrdp_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256
)(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [23:0] cfg_data
);
    localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
    // Series step h = 8/DEPTH in Q30.
    localparam logic [63:0] EXP_H = (64'd8 << 30) / EXP_TABLE_DEPTH;

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic logic [63:0] const_quo(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q, r;
        q = '0;
        r = '0;
        for (int n = 63; n >= 0; n--) begin
            r = {r[62:0], a[n]};
            if (r >= b) begin
                r = r - b;
                q[n] = 1'b1;
            end
        end
        return q;
    endfunction

    // Exp table built as powers of a truncated Q30 series step, rounded to Q16 per entry.
    typedef logic [16:0] tab_t [EXP_TABLE_DEPTH+1];
    function automatic tab_t build_tab();
        tab_t t;
        logic [63:0] term, cur, step;
        logic signed [63:0] sum;
        term = 64'd1 << 30;
        sum = 64'sd1 << 30;
        cur = 64'd1 << 30;
        for (int k = 1; k <= 25; k++) begin
            term = const_quo((term * EXP_H) >> 30, 64'(k));
            if ((k & 1) == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        step = sum;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            t[i] = 17'((cur + (64'd1 << 13)) >> 14);
            cur = (cur * step + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction
    localparam tab_t EXP_TAB = build_tab();

    typedef enum logic [4:0] {
        S_IDLE, S_ALPHA_L, S_DIV_L, S_LOOK_L, S_INT_L,
        S_ALPHA_A, S_DIV_A, S_LOOK_A, S_INT_A,
        S_LAG0, S_LAG1, S_LAG2, S_LAG3, S_RATE_H, S_DIV_H,
        S_RATE_M, S_DIV_M, S_PD_P, S_PD_D, S_TRIM, S_FIN, S_OUT
    } seq_t;

    seq_t state_reg, state_next;
    logic [23:0] tau_l_reg, tau_a_reg, kp_reg, kd_reg, kdist_reg, lim_reg;
    logic [31:0] last_reg;
    logic        seen_reg, phv_reg;
    logic signed [31:0] ds_reg, dm_reg, hs_reg, hm_reg, ph_reg, hm_old_reg;
    in_item_t    it_reg;
    logic [31:0] dt_reg;
    logic [16:0] al_reg, aa_reg;
    logic [63:0] pos_reg;
    logic signed [65:0] w_reg, omega_reg, mrate_reg;
    logic signed [65:0] v_reg;
    logic        neg_reg;
    out_item_t   out_reg;
    logic        ovalid_reg;

    // Shared multiplier: signed 33 by 33 with rounding, one use per step.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [65:0]        mag;
    logic signed [65:0] mul_r;

    div_req_t dreq;
    div_rsp_t drsp;
    mrdp_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;

    always_comb begin
        mul_p = mul_a * mul_b;
        mag   = mul_p[65] ? 66'(-mul_p) : mul_p;
        mag   = (mag + 66'd32768) >> 16;
        mul_r = mul_p[65] ? -$signed(mag) : $signed(mag);
    end

    logic [23:0] tau_cur;
    logic [16:0] e0, e1, e_int;
    logic [IW-1:0] idx;
    logic idx_over;
    assign tau_cur = (state_reg inside {S_ALPHA_L, S_DIV_L, S_LOOK_L, S_INT_L}) ?
                     tau_l_reg : tau_a_reg;
    assign idx_over = (pos_reg[63:16] >= 48'(EXP_TABLE_DEPTH));
    assign idx = pos_reg[16 +: IW];
    assign e0 = EXP_TAB[idx];
    assign e1 = EXP_TAB[idx + IW'(1)];
    assign e_int = e0 - 17'(((64'(e0 - e1) * pos_reg[15:0]) + 64'd32768) >> 16);

    logic [63:0] num_x, den_x;
    assign num_x = {16'd0, dt_reg, 16'd0};
    assign den_x = 64'(MS_PER_S) * {40'd0, tau_cur};
    logic alpha_one;
    assign alpha_one = (tau_cur == 24'd0) || (dt_reg == 32'd0) || (num_x >= (den_x << 3));

    // Division by dt of a signed difference: magnitude times 1000 then truncate.
    logic signed [32:0] diff_h, diff_m, diff_sel;
    logic [63:0] diff_mag;
    assign diff_h = 33'(hm_reg) - 33'(hm_old_reg);
    assign diff_m = 33'(it_reg.heading_measured) - 33'(ph_reg);
    assign diff_sel = (state_reg == S_RATE_H) ? diff_h : diff_m;
    assign diff_mag = 64'(diff_sel[32] ? -diff_sel : diff_sel) * 64'(MS_PER_S);
    logic signed [65:0] rate_q;
    assign rate_q = 66'(sat32(neg_reg ? -$signed({2'b0, drsp.quo}) : $signed({2'b0, drsp.quo})));

    logic signed [65:0] trim_c, lim_s;
    assign lim_s = $signed({42'd0, lim_reg});
    always_comb begin
        trim_c = mul_r;
        if (trim_c > lim_s) trim_c = lim_s;
        if (trim_c < -lim_s) trim_c = -lim_s;
        if (it_reg.within_tolerance) trim_c = '0;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LAG0: begin
                mul_a = 33'({1'b0, al_reg});
                mul_b = 33'(it_reg.dist_reference) - 33'(ds_reg);
            end
            S_LAG1: begin
                mul_a = 33'({1'b0, al_reg});
                mul_b = 33'(ds_reg) - 33'(dm_reg);
            end
            S_LAG2: begin
                mul_a = 33'({1'b0, aa_reg});
                mul_b = 33'(it_reg.heading_reference) - 33'(hs_reg);
            end
            S_LAG3: begin
                mul_a = 33'({1'b0, aa_reg});
                mul_b = 33'(hs_reg) - 33'(hm_reg);
            end
            S_PD_P: begin
                mul_a = 33'({9'd0, kp_reg});
                mul_b = 33'(hm_reg) - 33'(it_reg.heading_lead);
            end
            S_PD_D: begin
                mul_a = 33'({9'd0, kd_reg});
                mul_b = 33'(omega_reg - mrate_reg);
            end
            S_TRIM: begin
                mul_a = 33'({9'd0, kdist_reg});
                mul_b = 33'(dm_reg) - 33'(it_reg.dist_measured);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_ALPHA_L;
            S_ALPHA_L: state_next = alpha_one ? S_ALPHA_A : S_DIV_L;
            S_DIV_L:   if (drsp.done) state_next = S_LOOK_L;
            S_LOOK_L:  state_next = S_INT_L;
            S_INT_L:   state_next = S_ALPHA_A;
            S_ALPHA_A: state_next = alpha_one ? S_LAG0 : S_DIV_A;
            S_DIV_A:   if (drsp.done) state_next = S_LOOK_A;
            S_LOOK_A:  state_next = S_INT_A;
            S_INT_A:   state_next = S_LAG0;
            S_LAG0:    state_next = S_LAG1;
            S_LAG1:    state_next = S_LAG2;
            S_LAG2:    state_next = S_LAG3;
            S_LAG3:    state_next = (dt_reg == 32'd0) ? S_PD_P : S_RATE_H;
            S_RATE_H:  state_next = S_DIV_H;
            S_DIV_H:   if (drsp.done) state_next = (phv_reg ? S_RATE_M : S_PD_P);
            S_RATE_M:  state_next = S_DIV_M;
            S_DIV_M:   if (drsp.done) state_next = S_PD_P;
            S_PD_P:    state_next = S_PD_D;
            S_PD_D:    state_next = S_TRIM;
            S_TRIM:    state_next = S_FIN;
            S_FIN:     if (!ovalid_reg || m_ready) state_next = S_OUT;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        case (state_reg)
            S_ALPHA_L, S_ALPHA_A: begin
                dreq.start = !alpha_one;
                dreq.num   = num_x << 16;
                dreq.den   = den_x;
            end
            S_RATE_H, S_RATE_M: begin
                dreq.start = 1'b1;
                dreq.num   = diff_mag;
                dreq.den   = {32'd0, dt_reg};
            end
            default: ;
        endcase
    end

    logic signed [65:0] v_fin, w_fin;
    assign v_fin = v_reg;
    assign w_fin = w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tau_l_reg  <= '0;
            tau_a_reg  <= '0;
            kp_reg     <= 24'd393216;
            kd_reg     <= '0;
            kdist_reg  <= 24'd524288;
            lim_reg    <= 24'd6554;
            last_reg   <= '0;
            seen_reg   <= 1'b0;
            phv_reg    <= 1'b0;
            ds_reg     <= '0;
            dm_reg     <= '0;
            hs_reg     <= '0;
            hm_reg     <= '0;
            ph_reg     <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_LIN_TAU:  tau_l_reg <= cfg_data;
                    REG_ANG_TAU:  tau_a_reg <= cfg_data;
                    REG_GAIN_P:   kp_reg    <= cfg_data;
                    REG_GAIN_D:   kd_reg    <= cfg_data;
                    REG_DIST_P:   kdist_reg <= cfg_data;
                    REG_TRIM_LIM: lim_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    it_reg   <= s_data;
                    dt_reg   <= seen_reg ? s_data.now_ms - last_reg : 32'd0;
                    last_reg <= s_data.now_ms;
                    seen_reg <= 1'b1;
                    al_reg   <= 17'd65536;
                    aa_reg   <= 17'd65536;
                    omega_reg <= '0;
                    mrate_reg <= '0;
                end
                // The ratio stays below 8.0, so its quotient fits in 20 bits.
                S_DIV_L, S_DIV_A: if (drsp.done) begin
                    pos_reg <= {32'd0, 32'(drsp.quo[19:0]) * 32'(EXP_TABLE_DEPTH)} >> 3;
                end
                S_INT_L: al_reg <= idx_over ? 17'd65536 : 17'd65536 - e_int;
                S_INT_A: aa_reg <= idx_over ? 17'd65536 : 17'd65536 - e_int;
                S_LAG0: ds_reg <= sat32(66'(ds_reg) + mul_r);
                S_LAG1: dm_reg <= sat32(66'(dm_reg) + mul_r);
                S_LAG2: hs_reg <= sat32(66'(hs_reg) + mul_r);
                S_LAG3: begin
                    hm_old_reg <= hm_reg;
                    hm_reg     <= sat32(66'(hm_reg) + mul_r);
                end
                S_RATE_H, S_RATE_M: neg_reg <= diff_sel[32];
                S_DIV_H: if (drsp.done) omega_reg <= rate_q;
                S_DIV_M: if (drsp.done) mrate_reg <= rate_q;
                S_PD_P: w_reg <= 66'(it_reg.plan_turn_rate) + mul_r;
                S_PD_D: begin
                    if (!it_reg.heading_enable) w_reg <= 66'(it_reg.plan_turn_rate);
                    else w_reg <= w_reg + mul_r;
                    ph_reg  <= it_reg.heading_measured;
                    phv_reg <= 1'b1;
                end
                S_TRIM: v_reg <= 66'(it_reg.plan_velocity) + trim_c;
                S_OUT: begin
                    ovalid_reg <= 1'b1;
                    if (!it_reg.idle_after) begin
                        out_reg.stage_code    <= STAGE_TWIST;
                        out_reg.velocity_cmd  <= sat32(v_fin);
                        out_reg.turn_rate_cmd <= sat32(w_fin);
                    end else begin
                        out_reg.stage_code    <= it_reg.idle_before ? STAGE_NOTHING : STAGE_ZERO;
                        out_reg.velocity_cmd  <= '0;
                        out_reg.turn_rate_cmd <= '0;
                        ds_reg <= '0;
                        dm_reg <= '0;
                        hs_reg <= '0;
                        hm_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // A result must not be overwritten before it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (!ovalid_reg || m_ready))
        else $error("result overwritten");
    // No new item while one is in work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("ready during work");
    // The divider is only started when idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dreq.start && state_reg != S_IDLE) |=> !drsp.done)
        else $error("divider restarted early");
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the drive pilot: random and directed ticks against a predictor.
`default_nettype none
module testbench;
    import mrdp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    // An index past the last register; the block must ignore writes to it.
    localparam logic [2:0] REG_NONE = 3'd6;
    localparam int SETTLE_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    model_reference_drive_pilot #(.EXP_TABLE_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // The clock runs with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Ticks waiting to be sent, and the twist commands we expect back, oldest first.
    in_item_t  tick_queue[$];
    out_item_t twist_expected[$];
    int        error_count = 0;
    // While calm is set, neither side inserts idle cycles.
    bit        calm = 1'b0;

    // Shadow copy of the configuration registers, reset values first.
    logic [23:0] lin_tau = 24'd0;
    logic [23:0] ang_tau = 24'd0;
    logic [23:0] gain_p = 24'd393216;
    logic [23:0] gain_d = 24'd0;
    logic [23:0] dist_p = 24'd524288;
    logic [23:0] trim_lim = 24'd6554;

    // Shadow copy of the pilot's state, all zero after reset.
    logic [31:0] last_ms = '0;
    bit          seen = 1'b0;
    int          d_stage = 0, d_model = 0, h_stage = 0, h_model = 0;
    int          prev_hdg = 0;
    bit          prev_hdg_ok = 1'b0;

    longint unsigned exp_q16 [0:DEPTH];

    // Builds exp(-8*i/DEPTH) in Q16 from a truncated Q30 series for the single step.
    function automatic void build_exp_table();
        longint unsigned h, term, cur, step;
        longint sum;
        h = (longint'(8) << 30) / DEPTH;
        term = 64'd1 << 30;
        sum = longint'(term);
        cur = 64'd1 << 30;
        for (int k = 1; k <= 25; k++) begin
            term = ((term * h) >> 30) / longint'(k);
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        step = longint'(sum);
        for (int i = 0; i <= DEPTH; i++) begin
            exp_q16[i] = (cur + (64'd1 << 13)) >> 14;
            cur = (cur * step + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // Q16 product, rounded half away from zero.
    function automatic longint mul_round(longint a, longint b);
        bit neg;
        longint unsigned ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : longint'(a);
        mb = (b < 0) ? longint'(-b) : longint'(b);
        p = (ma * mb + 64'd32768) >> 16;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Lag coefficient 1 - exp(-dt/tau) in Q16, interpolated from the table.
    function automatic longint lag_coeff(logic [31:0] dt, logic [23:0] tau);
        longint unsigned num, den, xq, pos, idx, frac, e;
        if (tau == 0 || dt == 0) begin
            return 65536;
        end
        num = longint'(dt) << 16;
        den = 64'd1000 * longint'(tau);
        if (num >= 8 * den) begin
            return 65536;
        end
        xq = (num << 16) / den;
        pos = xq * DEPTH / 8;
        idx = pos >> 16;
        if (idx >= DEPTH) begin
            return 65536;
        end
        frac = pos & 64'hFFFF;
        e = exp_q16[idx] - (((exp_q16[idx] - exp_q16[idx + 1]) * frac + 64'd32768) >> 16);
        return 65536 - longint'(e);
    endfunction

    function automatic int lag_advance(int cur, longint target, longint coeff);
        return clamp32(longint'(cur) + mul_round(coeff, target - longint'(cur)));
    endfunction

    function automatic longint rate_per_s(longint diff, logic [31:0] dt);
        if (dt == 0) begin
            return 0;
        end
        return clamp32(diff * 1000 / longint'(dt));
    endfunction

    // Advances the shadow state by one tick and queues the twist the block should return.
    function automatic void predict_twist(in_item_t it);
        logic [31:0] dt;
        longint al, aa, omega, w, v, trim, err, meas_rate;
        int new_model;
        out_item_t res;
        dt = seen ? it.now_ms - last_ms : 32'd0;
        last_ms = it.now_ms;
        seen = 1'b1;
        al = lag_coeff(dt, lin_tau);
        aa = lag_coeff(dt, ang_tau);
        d_stage = lag_advance(d_stage, longint'(it.dist_reference), al);
        d_model = lag_advance(d_model, longint'(d_stage), al);
        h_stage = lag_advance(h_stage, longint'(it.heading_reference), aa);
        new_model = lag_advance(h_model, longint'(h_stage), aa);
        omega = rate_per_s(longint'(new_model) - longint'(h_model), dt);
        h_model = new_model;

        w = longint'(it.plan_turn_rate);
        if (it.heading_enable) begin
            err = longint'(h_model) - longint'(it.heading_lead);
            meas_rate = prev_hdg_ok ?
                rate_per_s(longint'(it.heading_measured) - longint'(prev_hdg), dt) : 0;
            w = w + mul_round(longint'(gain_p), err)
                  + mul_round(longint'(gain_d), omega - meas_rate);
        end
        prev_hdg = it.heading_measured;
        prev_hdg_ok = 1'b1;

        trim = 0;
        if (!it.within_tolerance) begin
            trim = mul_round(longint'(dist_p), longint'(d_model) - longint'(it.dist_measured));
            if (trim > longint'(trim_lim)) begin
                trim = longint'(trim_lim);
            end
            if (trim < -longint'(trim_lim)) begin
                trim = -longint'(trim_lim);
            end
        end
        v = longint'(it.plan_velocity) + trim;

        if (!it.idle_after) begin
            res.stage_code = STAGE_TWIST;
        end else begin
            res.stage_code = it.idle_before ? STAGE_NOTHING : STAGE_ZERO;
            v = 0;
            w = 0;
            d_stage = 0;
            d_model = 0;
            h_stage = 0;
            h_model = 0;
        end
        res.velocity_cmd = clamp32(v);
        res.turn_rate_cmd = clamp32(w);
        twist_expected.push_back(res);
    endfunction

    // Driver: presents queued ticks, holding each one until it is accepted.
    always @(posedge aclk) begin : driver
        bit holding;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid;
            if (s_valid && s_ready) begin
                predict_twist(s_data);
                holding = 1'b0;
            end
            if (!holding) begin
                if (tick_queue.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
                    s_data <= tick_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the result side at random and checks every accepted twist.
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (m_valid && m_ready && aresetn) begin
            if (twist_expected.size() == 0) begin
                $error("unexpected result item: %h", m_data);
                error_count++;
            end else begin
                want = twist_expected.pop_front();
                if (m_data.velocity_cmd !== want.velocity_cmd) begin
                    $error("velocity_cmd: expected %0d, got %0d",
                           want.velocity_cmd, m_data.velocity_cmd);
                    error_count++;
                end
                if (m_data.turn_rate_cmd !== want.turn_rate_cmd) begin
                    $error("turn_rate_cmd: expected %0d, got %0d",
                           want.turn_rate_cmd, m_data.turn_rate_cmd);
                    error_count++;
                end
                if (m_data.stage_code !== want.stage_code) begin
                    $error("stage_code: expected %0d, got %0d",
                           want.stage_code, m_data.stage_code);
                    error_count++;
                end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 24);
    end

    // Writes one register and mirrors it in the shadow copy.
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_LIN_TAU:  lin_tau = val;
            REG_ANG_TAU:  ang_tau = val;
            REG_GAIN_P:   gain_p = val;
            REG_GAIN_D:   gain_d = val;
            REG_DIST_P:   dist_p = val;
            REG_TRIM_LIM: trim_lim = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] lt, logic [23:0] at, logic [23:0] gp,
                             logic [23:0] gd, logic [23:0] dp, logic [23:0] tl);
        write_reg(REG_LIN_TAU, lt);
        write_reg(REG_ANG_TAU, at);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_DIST_P, dp);
        write_reg(REG_TRIM_LIM, tl);
    endtask

    // Waits until every tick has gone in and every twist has come back, then lets the
    // block settle before anything is reconfigured.
    task automatic drain();
        while (tick_queue.size() > 0 || s_valid || twist_expected.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stimulus state: the running clock and whether the executor is moving.
    logic [31:0] clock_ms = 32'd0;
    bit          moving = 1'b0;

    // Mostly small signal values, with the extremes and full-range noise mixed in.
    function automatic logic signed [31:0] pick_signal();
        case ($urandom_range(19))
            0: return $urandom;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            default: return int'($urandom_range(2 * 196608)) - 196608;
        endcase
    endfunction

    function automatic in_item_t random_tick();
        in_item_t it;
        case ($urandom_range(19))
            0: clock_ms = clock_ms;
            1: clock_ms = clock_ms + $urandom;
            2: clock_ms = clock_ms + $urandom_range(3000, 100);
            default: clock_ms = clock_ms + $urandom_range(20, 1);
        endcase
        it.now_ms = clock_ms;
        it.plan_velocity = pick_signal();
        it.plan_turn_rate = pick_signal();
        it.dist_reference = pick_signal();
        it.dist_measured = pick_signal();
        it.heading_reference = pick_signal();
        it.heading_measured = pick_signal();
        it.heading_lead = pick_signal();
        it.heading_enable = ($urandom_range(3) != 0);
        it.within_tolerance = ($urandom_range(3) == 0);
        // Mostly a well-formed start, run, stop, idle sequence, with some noise.
        if ($urandom_range(19) == 0) begin
            it.idle_before = 1'($urandom_range(1));
            it.idle_after = 1'($urandom_range(1));
        end else if (moving) begin
            it.idle_before = 1'b0;
            it.idle_after = ($urandom_range(19) == 0);
            moving = !it.idle_after;
        end else begin
            it.idle_before = 1'b1;
            it.idle_after = ($urandom_range(9) >= 6);
            moving = !it.idle_after;
        end
        return it;
    endfunction

    function automatic in_item_t make_tick(logic [31:0] t, int v, int w, int sr, int sm,
                                           int hr, int hm, int hl, logic [3:0] flags);
        in_item_t it;
        it.now_ms = t;
        it.plan_velocity = v;
        it.plan_turn_rate = w;
        it.dist_reference = sr;
        it.dist_measured = sm;
        it.heading_reference = hr;
        it.heading_measured = hm;
        it.heading_lead = hl;
        {it.heading_enable, it.within_tolerance, it.idle_before, it.idle_after} = flags;
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            tick_queue.push_back(random_tick());
        end
        drain();
    endtask

    localparam int MAXI = 32'sh7FFFFFFF;
    localparam int MINI = 32'sh80000000;

    initial begin
        build_exp_table();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under the reset configuration. Flags are
        // {heading_enable, within_tolerance, idle_before, idle_after}.
        // The first tick has no interval, and the second repeats its time for a zero interval.
        tick_queue.push_back(make_tick(32'd100, MAXI, MAXI, MAXI, MINI, MAXI, MINI, MINI, 4'b1000));
        tick_queue.push_back(make_tick(32'd100, MINI, MINI, MINI, MAXI, MINI, MAXI, MAXI, 4'b1000));
        tick_queue.push_back(make_tick(32'd101, 65536, 0, 65536, 0, 32768, 0, 0, 4'b1000));
        tick_queue.push_back(make_tick(32'd102, 0, 65536, 131072, 65536, 0, 1000, 0, 4'b0000));
        tick_queue.push_back(make_tick(32'd103, 100, 200, 0, 0, 5000, 0, 9, 4'b1100));
        // Running stops, stays idle, then starts again.
        tick_queue.push_back(make_tick(32'd104, 65536, 65536, 1, 2, 3, 4, 5, 4'b1001));
        tick_queue.push_back(make_tick(32'd105, 65536, 65536, 1, 2, 3, 4, 5, 4'b1011));
        tick_queue.push_back(make_tick(32'd106, 65536, 65536, 1, 2, 3, 4, 5, 4'b1010));
        // A long gap and the clock wrapping past its top.
        tick_queue.push_back(make_tick(32'hFFFFFFF0, 7, -7, 70000, -70000, 9, -9, 3, 4'b1000));
        tick_queue.push_back(make_tick(32'h00000005, -7, 7, -70000, 70000, -9, 9, -3, 4'b1000));
        tick_queue.push_back(make_tick(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 4'b0101));
        tick_queue.push_back(make_tick(32'h00000000, MAXI, MINI, MAXI, MAXI, MINI, MINI, MAXI,
                                       4'b1000));
        tick_queue.push_back(make_tick(32'h00000001, MINI, MAXI, MINI, MINI, MAXI, MAXI, MINI,
                                       4'b0000));
        clock_ms = 32'd1;
        drain();

        // Moderate lags and gains, with an ignored write past the last register.
        write_all(24'd3277, 24'd1311, 24'd200000, 24'd30000, 24'd400000, 24'd30000);
        write_reg(REG_NONE, 24'hFFFFFF);
        random_phase(220);

        // Every register at its top.
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_phase(100);

        // Smallest nonzero lags, zero gains and a zero clamp, with no idling on either side.
        calm = 1'b1;
        write_all(24'd1, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0);
        random_phase(100);
        calm = 1'b0;

        // Random settings, with lags kept where the table is used most of the time.
        for (int p = 0; p < 4; p++) begin
            write_all(24'($urandom_range(20000)), 24'($urandom_range(20000)),
                      24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(200000)),
                      24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)));
            random_phase(70);
        end

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #10ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/mrdp_pkg.sv
sv/mrdp_div.sv
sv/model_reference_drive_pilot.sv
tb/sv/testbench.sv
